>>> rtl/dpt_pkg.sv
// Shared types, codes and constants for the divider and programmable timer.
package dpt_pkg;

    // Ticks per divider step.
    localparam int DIV_PERIOD = 64;
    localparam int SUB_W      = (DIV_PERIOD > 1) ? $clog2(DIV_PERIOD) : 1;
    localparam logic [SUB_W-1:0] SUB_LAST = SUB_W'(DIV_PERIOD - 1);

    localparam int PRESCALE_W = 9;
    localparam int TAC_ENABLE_BIT = 2;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_READ  = 2'd1,
        OP_WRITE = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        SEL_DIV  = 2'd0,
        SEL_TIMA = 2'd1,
        SEL_TMA  = 2'd2,
        SEL_TAC  = 2'd3
    } sel_t;

    localparam logic STATUS_OK         = 1'b0;
    localparam logic STATUS_DIV_REJECT = 1'b1;

    typedef struct packed {
        logic [7:0] read_data;
        logic       timer_irq;
        logic       status;
    } result_t;

    // Prescaler period chosen by the low two control bits.
    function automatic logic [PRESCALE_W-1:0] period_of(input logic [1:0] clk_sel);
        logic [PRESCALE_W-1:0] p;
        unique case (clk_sel)
            2'd0:    p = PRESCALE_W'(256);
            2'd1:    p = PRESCALE_W'(4);
            2'd2:    p = PRESCALE_W'(16);
            default: p = PRESCALE_W'(64);
        endcase
        return p;
    endfunction

endpackage

>>> rtl/dpt_core.sv
// Timer state registers and the single-pass update for one accepted word.
module dpt_core (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            accept,
    input  logic [1:0]      operation,
    input  logic [1:0]      reg_select,
    input  logic [7:0]      write_data,
    output dpt_pkg::result_t result
);
    import dpt_pkg::*;

    // The cycle count is kept as divider byte plus a sub-count below DIV_PERIOD.
    logic [SUB_W-1:0]      sub_reg, sub_next;
    logic [7:0]            div_reg, div_next;
    logic [PRESCALE_W-1:0] presc_reg, presc_next;
    logic [7:0]            tima_reg, tima_next;
    logic [7:0]            tma_reg, tma_next;
    logic [7:0]            tac_reg, tac_next;

    logic [PRESCALE_W-1:0] presc_inc;
    logic [PRESCALE_W-1:0] period;
    op_t                   op;
    sel_t                  sel;

    assign op        = op_t'(operation);
    assign sel       = sel_t'(reg_select);
    assign period    = period_of(tac_reg[1:0]);
    assign presc_inc = presc_reg + PRESCALE_W'(1);

    always_comb begin
        sub_next   = sub_reg;
        div_next   = div_reg;
        presc_next = presc_reg;
        tima_next  = tima_reg;
        tma_next   = tma_reg;
        tac_next   = tac_reg;
        result     = '{read_data: 8'd0, timer_irq: 1'b0, status: STATUS_OK};

        unique case (op)
            OP_TICK: begin
                if (sub_reg == SUB_LAST) begin
                    sub_next = '0;
                    div_next = div_reg + 8'd1;
                end else begin
                    sub_next = sub_reg + SUB_W'(1);
                end
                if (tac_reg[TAC_ENABLE_BIT]) begin
                    presc_next = presc_inc;
                    // After a period switch only one step is taken per tick.
                    if (presc_inc >= period) begin
                        presc_next = presc_inc - period;
                        if (tima_reg == 8'hFF) begin
                            tima_next        = tma_reg;
                            result.timer_irq = 1'b1;
                        end else begin
                            tima_next = tima_reg + 8'd1;
                        end
                    end
                end
            end
            OP_READ: begin
                unique case (sel)
                    SEL_DIV:  result.read_data = div_reg;
                    SEL_TIMA: result.read_data = tima_reg;
                    SEL_TMA:  result.read_data = tma_reg;
                    default:  result.read_data = tac_reg;
                endcase
            end
            OP_WRITE: begin
                unique case (sel)
                    SEL_DIV:  result.status = STATUS_DIV_REJECT;
                    SEL_TIMA: tima_next = write_data;
                    SEL_TMA:  tma_next  = write_data;
                    default:  tac_next  = write_data;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sub_reg   <= '0;
            div_reg   <= '0;
            presc_reg <= '0;
            tima_reg  <= '0;
            tma_reg   <= '0;
            tac_reg   <= '0;
        end else if (accept) begin
            sub_reg   <= sub_next;
            div_reg   <= div_next;
            presc_reg <= presc_next;
            tima_reg  <= tima_next;
            tma_reg   <= tma_next;
            tac_reg   <= tac_next;
        end
    end

endmodule

>>> rtl/dpt_out_reg.sv
// Result register that holds one word for the receiver and drives input ready.
module dpt_out_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              accept,
    input  dpt_pkg::result_t  result,
    output logic              m_valid,
    input  logic              m_ready,
    output dpt_pkg::result_t  m_result
);
    import dpt_pkg::*;

    logic    valid_reg;
    result_t data_reg;

    // A new word may enter whenever the register is empty or the held one leaves in the same cycle.
    assign s_ready  = !valid_reg || m_ready;
    assign accept   = s_valid && s_ready;
    assign m_valid  = valid_reg;
    assign m_result = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            data_reg <= result;
        end
    end

endmodule

>>> rtl/divider_and_programmable_timer.sv
// Top level of the divider and programmable timer.
//
// Input channel (s_valid/s_ready): each word is a machine-cycle tick, a read
// or a write of one of four registers: divider, counter, modulo, control.
// Result channel (m_valid/m_ready): exactly one word per input word, in
// order, carrying read data, the timer interrupt pulse and a status bit.
//
// An accepted word's result is registered in the result register. Throughput
// is one word per clock while the receiver does not stall; the state update
// and result are one pass of logic from the timer registers into it.
//
// When the receiver stalls, the result register holds its word and s_ready
// falls; it rises again in the cycle m_ready is seen, so no bubble appears.
//
// Synchronous active-low reset clears the divider, prescaler, counter,
// modulo and control registers and empties the result register.
module divider_and_programmable_timer (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_operation,
    input  logic [1:0] s_reg_select,
    input  logic [7:0] s_write_data,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_read_data,
    output logic       m_timer_irq,
    output logic       m_status
);
    import dpt_pkg::*;

    logic    accept;
    result_t result;
    result_t m_result;

    dpt_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .operation  (s_operation),
        .reg_select (s_reg_select),
        .write_data (s_write_data),
        .result     (result)
    );

    dpt_out_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .accept   (accept),
        .result   (result),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (m_result)
    );

    assign m_read_data = m_result.read_data;
    assign m_timer_irq = m_result.timer_irq;
    assign m_status    = m_result.status;

endmodule

>>> rtl/dpt_checker.sv
// Port-level assertions for the divider and programmable timer, bound to the top.
module dpt_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic [1:0] s_operation,
    input logic [1:0] s_reg_select,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_read_data,
    input logic       m_timer_irq,
    input logic       m_status
);
    import dpt_pkg::*;

    // Every accepted word yields its result word in the next cycle.
    a_one_cycle_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("result word missing one cycle after accept");

    // Only a tick can pulse the interrupt.
    a_irq_only_on_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_operation != OP_TICK) |=> !m_timer_irq)
        else $error("timer interrupt on a non-tick word");

    // A write to the divider is rejected with status and no data.
    a_div_write_reject: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_operation == OP_WRITE) && (s_reg_select == SEL_DIV)
        |=> m_status && (m_read_data == 8'd0))
        else $error("divider write not rejected");

    // Status is only set by a write, so it never comes with a read value.
    a_status_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status |-> (m_read_data == 8'd0) && !m_timer_irq)
        else $error("status set together with data or interrupt");

    // A stalled result word holds.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_read_data)
            && $stable(m_timer_irq) && $stable(m_status))
        else $error("stalled result word changed");

endmodule

bind divider_and_programmable_timer dpt_checker u_dpt_checker (.*);
